>>> design/atod_pkg.sv
`timescale 1ns / 1ps

package atod_pkg;

    localparam int FEATURE_W   = 16;
    localparam int COEFF_W     = 12;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 12;
    localparam int FRAC_BITS   = 8;

    localparam int HISTORY_DEPTH_DEFAULT = 10;

    localparam logic [FEATURE_W-1:0] THRESHOLD_RESET = FEATURE_W'(26);
    localparam logic [COEFF_W-1:0]   COEFF_RESET     = COEFF_W'(384);
    localparam logic [FEATURE_W-1:0] FEATURE_MAX     = {FEATURE_W{1'b1}};

    localparam logic [CFG_INDEX_W-1:0] REG_USE_LOCAL_MAX = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_MEAN_COEFF    = CFG_INDEX_W'(1);

    typedef struct packed {
        logic use_reset_thr;
        logic local_max;
    } pick_ctl_t;

endpackage

>>> design/adaptive_threshold_onset_detector_top.sv
`timescale 1ns / 1ps

// Adaptive-threshold onset detector.
// s_ channel: one feature word per audio frame (unsigned Q8.8), valid/ready.
// m_ channel: one is_onset word per accepted feature word, in order.
// cfg channel: cfg_index 0 selects local-maximum picking (bit 0 of cfg_data),
// index 1 sets the Q4.8 mean coefficient; other indexes are dropped.
// cfg_ready is always high; write only while the block is idle.
// Each accepted word passes capture, mean, threshold, then output register.
// Throughput: one word per cycle while m_ready stays high, set by the history
// cell row that shifts once per accepted word and by the four-register
// divide/multiply/compare pipeline behind it.
// The threshold for a frame comes from the running sum and the coefficient
// held when the previous frame was taken; both travel down the pipeline with
// the word. The frame itself sees the history before its own shift.
// Reset (aresetn low, synchronous) clears the history, the sum, the pipeline
// and the registers to local-maximum mode with coefficient 1.5; the first
// frame after reset is judged against a threshold of 0.1.
// When m_ready is low, results collect in the pipeline stages; s_ready drops
// only once every stage holds a word.
module adaptive_threshold_onset_detector_top #(
    parameter int HISTORY_DEPTH = atod_pkg::HISTORY_DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [atod_pkg::FEATURE_W-1:0]      s_feature_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_is_onset,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [atod_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [atod_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int FW    = atod_pkg::FEATURE_W;
    localparam int SUM_W = FW + $clog2(HISTORY_DEPTH);

    logic [FW-1:0]                  hist [HISTORY_DEPTH];
    logic [SUM_W-1:0]               sum_reg, sum_next;
    logic [SUM_W-1:0]               last_sum_reg;
    logic [atod_pkg::COEFF_W-1:0]   last_coeff_reg;
    logic                           started_reg;
    logic                           local_max_reg;
    logic [atod_pkg::COEFF_W-1:0]   coeff_reg;
    logic                           accept;
    atod_pkg::pick_ctl_t            ctl;

    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // history row: cell 0 holds the newest word
    genvar gi;
    generate
        for (gi = 0; gi < HISTORY_DEPTH; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                atod_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .shift_en (accept),
                    .d_in     (s_feature_value),
                    .q_out    (hist[gi])
                );
            end else begin : g_body
                atod_cell u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .shift_en (accept),
                    .d_in     (hist[gi-1]),
                    .q_out    (hist[gi])
                );
            end
        end
    endgenerate

    assign sum_next = sum_reg - SUM_W'(hist[HISTORY_DEPTH-1]) + SUM_W'(s_feature_value);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg        <= '0;
            last_sum_reg   <= '0;
            last_coeff_reg <= atod_pkg::COEFF_RESET;
            started_reg    <= 1'b0;
        end else if (accept) begin
            sum_reg        <= sum_next;
            last_sum_reg   <= sum_reg;
            last_coeff_reg <= coeff_reg;
            started_reg    <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_max_reg <= 1'b1;
            coeff_reg     <= atod_pkg::COEFF_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                atod_pkg::REG_USE_LOCAL_MAX: local_max_reg <= cfg_data[0];
                atod_pkg::REG_MEAN_COEFF:    coeff_reg <= cfg_data[atod_pkg::COEFF_W-1:0];
                default: ;
            endcase
        end
    end

    assign ctl.use_reset_thr = !started_reg;
    assign ctl.local_max     = local_max_reg;

    atod_pick #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SUM_W         (SUM_W)
    ) u_pick (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .feature   (s_feature_value),
        .newest    (hist[0]),
        .second    (hist[1]),
        .prev_sum  (last_sum_reg),
        .ctl       (ctl),
        .coeff     (last_coeff_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_onset (m_is_onset)
    );

endmodule

>>> design/atod_cell.sv
`timescale 1ns / 1ps

module atod_cell (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            shift_en,
    input  logic [atod_pkg::FEATURE_W-1:0]  d_in,
    output logic [atod_pkg::FEATURE_W-1:0]  q_out
);

    logic [atod_pkg::FEATURE_W-1:0] value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
        end else if (shift_en) begin
            value_reg <= d_in;
        end
    end

    assign q_out = value_reg;

endmodule

>>> design/atod_pick.sv
`timescale 1ns / 1ps

module atod_pick #(
    parameter int HISTORY_DEPTH = atod_pkg::HISTORY_DEPTH_DEFAULT,
    parameter int SUM_W         = atod_pkg::FEATURE_W + $clog2(HISTORY_DEPTH)
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [atod_pkg::FEATURE_W-1:0]  feature,
    input  logic [atod_pkg::FEATURE_W-1:0]  newest,
    input  logic [atod_pkg::FEATURE_W-1:0]  second,
    input  logic [SUM_W-1:0]                prev_sum,
    input  atod_pkg::pick_ctl_t             ctl,
    input  logic [atod_pkg::COEFF_W-1:0]    coeff,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            out_onset
);

    localparam int FW    = atod_pkg::FEATURE_W;
    localparam int LD    = $clog2(HISTORY_DEPTH);
    localparam int RK    = SUM_W + LD;
    localparam int RM_W  = SUM_W + 1;
    localparam logic [RM_W-1:0] RECIP =
        RM_W'(((64'd1 << RK) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));
    localparam int DP_W  = SUM_W + RM_W;
    localparam int CP_W  = atod_pkg::COEFF_W + FW;
    localparam int CS_W  = CP_W - atod_pkg::FRAC_BITS;

    // stage 1: captured word
    logic                           v1_reg;
    logic [FW-1:0]                  x1_reg, h0_1_reg, h1_1_reg;
    logic [SUM_W-1:0]               sum1_reg;
    logic [atod_pkg::COEFF_W-1:0]   coeff1_reg;
    atod_pkg::pick_ctl_t            ctl1_reg;
    // stage 2: mean
    logic                           v2_reg;
    logic [FW-1:0]                  x2_reg, h0_2_reg, h1_2_reg, mean2_reg;
    logic [atod_pkg::COEFF_W-1:0]   coeff2_reg;
    atod_pkg::pick_ctl_t            ctl2_reg;
    // stage 3: threshold
    logic                           v3_reg;
    logic [FW-1:0]                  x3_reg, h0_3_reg, h1_3_reg, thr3_reg;
    atod_pkg::pick_ctl_t            ctl3_reg;
    // output register
    logic                           vo_reg;
    logic                           onset_reg;

    logic                           rdy1, rdy2, rdy3;
    logic [DP_W-1:0]                div_prod;
    logic [CP_W-1:0]                coeff_prod;
    logic [CS_W-1:0]                scaled;
    logic [FW-1:0]                  thr_next;
    logic                           onset_next;

    assign rdy3     = !vo_reg || out_ready;
    assign rdy2     = !v3_reg || rdy3;
    assign rdy1     = !v2_reg || rdy2;
    assign in_ready = !v1_reg || rdy1;

    // floor divide by the depth: reciprocal multiply, exact over the sum range
    assign div_prod   = DP_W'(sum1_reg) * DP_W'(RECIP);
    assign coeff_prod = CP_W'(coeff2_reg) * CP_W'(mean2_reg);
    assign scaled     = coeff_prod[CP_W-1:atod_pkg::FRAC_BITS];

    always_comb begin
        if (ctl2_reg.use_reset_thr) begin
            thr_next = atod_pkg::THRESHOLD_RESET;
        end else if (scaled > CS_W'(atod_pkg::FEATURE_MAX)) begin
            thr_next = atod_pkg::FEATURE_MAX;
        end else begin
            thr_next = scaled[FW-1:0];
        end
    end

    always_comb begin
        if (ctl3_reg.local_max) begin
            onset_next = (h0_3_reg > thr3_reg) && (h0_3_reg > x3_reg) &&
                         (h0_3_reg > h1_3_reg);
        end else begin
            onset_next = x3_reg > thr3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (in_ready) v1_reg <= in_valid;
            if (rdy1)     v2_reg <= v1_reg;
            if (rdy2)     v3_reg <= v2_reg;
            if (rdy3)     vo_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            x1_reg     <= feature;
            h0_1_reg   <= newest;
            h1_1_reg   <= second;
            sum1_reg   <= prev_sum;
            coeff1_reg <= coeff;
            ctl1_reg   <= ctl;
        end
        if (rdy1) begin
            x2_reg     <= x1_reg;
            h0_2_reg   <= h0_1_reg;
            h1_2_reg   <= h1_1_reg;
            mean2_reg  <= div_prod[RK +: FW];
            coeff2_reg <= coeff1_reg;
            ctl2_reg   <= ctl1_reg;
        end
        if (rdy2) begin
            x3_reg   <= x2_reg;
            h0_3_reg <= h0_2_reg;
            h1_3_reg <= h1_2_reg;
            thr3_reg <= thr_next;
            ctl3_reg <= ctl2_reg;
        end
        if (rdy3) begin
            onset_reg <= onset_next;
        end
    end

    assign out_valid = vo_reg;
    assign out_onset = onset_reg;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH = atod_pkg::HISTORY_DEPTH_DEFAULT;
    localparam int FW    = atod_pkg::FEATURE_W;
    localparam int CW    = atod_pkg::COEFF_W;
    localparam int IW    = atod_pkg::CFG_INDEX_W;
    localparam int DW    = atod_pkg::CFG_DATA_W;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [FW-1:0]          s_feature_value = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_is_onset;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [IW-1:0]          cfg_index = '0;
    logic [DW-1:0]          cfg_data = '0;

    adaptive_threshold_onset_detector_top #(
        .HISTORY_DEPTH(DEPTH)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_feature_value(s_feature_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_is_onset     (m_is_onset),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // detector shadow state
    logic [FW-1:0] hist [DEPTH] = '{default: '0};
    int unsigned   hist_sum = 0;
    logic [FW-1:0] onset_thr = atod_pkg::THRESHOLD_RESET;
    logic          lm_mode = 1'b1;
    logic [CW-1:0] coeff = atod_pkg::COEFF_RESET;

    logic [FW-1:0] feature_pending [$];
    bit            onset_expected [$];
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            items_queued = 0;
    int            results_checked = 0;
    int            onsets_seen = 0;
    int            cfg_writes = 0;
    int            fail_count = 0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("tb: errors");
        $finish;
    end

    function automatic bit predict_onset(input logic [FW-1:0] x);
        bit              hit;
        longint unsigned scaled;
        int              i;
        if (lm_mode) begin
            hit = (hist[0] > onset_thr) && (hist[0] > x) && (hist[0] > hist[1]);
        end else begin
            hit = x > onset_thr;
        end
        // threshold uses the history before this frame is shifted in
        scaled = (longint'(coeff) * longint'(hist_sum / DEPTH)) >> atod_pkg::FRAC_BITS;
        onset_thr = (scaled > atod_pkg::FEATURE_MAX) ? atod_pkg::FEATURE_MAX
                                                     : scaled[FW-1:0];
        hist_sum = hist_sum - hist[DEPTH-1] + x;
        for (i = DEPTH - 1; i > 0; i--) begin
            hist[i] = hist[i-1];
        end
        hist[0] = x;
        return hit;
    endfunction

    function automatic void apply_register(input logic [IW-1:0] idx,
                                           input logic [DW-1:0] data);
        case (idx)
            atod_pkg::REG_USE_LOCAL_MAX: begin
                lm_mode = data[0];
            end
            atod_pkg::REG_MEAN_COEFF: begin
                coeff = data[CW-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    // driver: advance to the next pending word once the current one is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (feature_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_valid         <= 1'b1;
                s_feature_value <= feature_pending.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: track accepted words and check results in order
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                apply_register(cfg_index, cfg_data);
            end
            if (s_valid && s_ready) begin
                onset_expected.push_back(predict_onset(s_feature_value));
            end
            if (m_valid && m_ready) begin
                if (onset_expected.size() == 0) begin
                    $error("is_onset: unexpected result word, got %0d", m_is_onset);
                    fail_count++;
                end else begin
                    bit want;
                    want = onset_expected.pop_front();
                    if (m_is_onset !== want) begin
                        $error("is_onset: expected %0d, got %0d", want, m_is_onset);
                        fail_count++;
                    end
                    results_checked++;
                    if (want) onsets_seen++;
                end
            end
        end
    end

    task automatic write_register(input logic [IW-1:0] idx,
                                  input logic [DW-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (feature_pending.size() != 0 || s_valid || onset_expected.size() != 0);
        // let the pipeline drain past its latency
        repeat (8) @(negedge aclk);
    endtask

    task automatic push_word(input int v);
        feature_pending.push_back((v > atod_pkg::FEATURE_MAX) ? atod_pkg::FEATURE_MAX
                                                              : v[FW-1:0]);
        items_queued++;
    endtask

    task automatic queue_random(input int count);
        int stop_at;
        int kind;
        int base;
        int peak;
        int v;
        stop_at = items_queued + count;
        while (items_queued < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 55) begin
                // quiet floor, a peak, then a decay
                base = $urandom_range(0, 3000);
                repeat ($urandom_range(2, 8)) push_word(base + $urandom_range(0, base / 4 + 1));
                peak = base + $urandom_range(1, 40000);
                if (peak > atod_pkg::FEATURE_MAX) peak = atod_pkg::FEATURE_MAX;
                push_word(peak);
                if ($urandom_range(3) == 0) push_word(peak);
                push_word(peak - $urandom_range(0, peak / 2));
                if ($urandom_range(1) == 0) push_word(base);
            end else if (kind < 75) begin
                repeat ($urandom_range(1, 4)) push_word($urandom_range(0, 65535));
            end else if (kind < 88) begin
                v = ($urandom_range(1) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 400);
                repeat ($urandom_range(2, 4)) push_word(v);
            end else begin
                repeat ($urandom_range(1, 6)) push_word($urandom_range(0, 63));
            end
        end
    endtask

    initial begin
        logic [IW-1:0] unused_idx;
        logic [CW-1:0] seg_coeff;
        int            seg;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: local-maximum picking, coefficient 1.5
        push_word(0);     push_word(26);    push_word(27);    push_word(26);
        push_word(100);   push_word(100);   push_word(50);    push_word(65535);
        push_word(65535); push_word(0);     push_word(300);   push_word(299);
        wait_idle();

        // plain crossing with a zero threshold; upper data bits must be dropped
        write_register(atod_pkg::REG_USE_LOCAL_MAX, 12'hFFE);
        write_register(atod_pkg::REG_MEAN_COEFF, 12'h000);
        write_register(IW'(15), 12'hFFF);
        push_word(0); push_word(1); push_word(26); push_word(0);
        wait_idle();

        // largest coefficient on a full-scale history saturates the threshold
        write_register(atod_pkg::REG_MEAN_COEFF, 12'hFFF);
        repeat (10) push_word(65535);
        push_word(65535);
        push_word(65534);
        wait_idle();

        for (seg = 0; seg < 8; seg++) begin
            case (seg)
                0: seg_coeff = atod_pkg::COEFF_RESET;
                1: seg_coeff = '0;
                2: seg_coeff = '1;
                3: seg_coeff = CW'(256);
                4: seg_coeff = CW'(1);
                5: seg_coeff = CW'(2048);
                default: seg_coeff = CW'($urandom_range(0, 4095));
            endcase
            write_register(atod_pkg::REG_USE_LOCAL_MAX,
                           {(DW-1)'($urandom_range(0, 2047)), 1'(seg % 2 == 0)});
            write_register(atod_pkg::REG_MEAN_COEFF, DW'(seg_coeff));
            if ($urandom_range(1) == 0) begin
                unused_idx = IW'($urandom_range(2, 15));
                write_register(unused_idx, DW'($urandom_range(0, 4095)));
            end
            @(negedge aclk);
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            if (seg == 3) begin
                // hold the sender until every result is back, then resume
                queue_random(84);
                wait_idle();
                queue_random(84);
            end else begin
                queue_random(168);
            end
            wait_idle();
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end

        wait_idle();
        if (onset_expected.size() != 0) begin
            $error("is_onset: %0d results never arrived", onset_expected.size());
            fail_count++;
        end
        $display("summary: %0d feature words checked, %0d onsets, %0d register writes",
                 results_checked, onsets_seen, cfg_writes);
        $display("summary: both picking modes, coefficients 0 to 4095, four idle patterns");
        if (fail_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

>>> sim.f
design/atod_pkg.sv
design/atod_cell.sv
design/atod_pick.sv
design/adaptive_threshold_onset_detector_top.sv
tb/tb.sv
